[sv/signed_integer_to_radix_digits_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the radix digit core
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication
`define SIRTD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SIRTD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SIRTD_ASSERT_IMP(label, ante, cons, msg)
`define SIRTD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[sv/sirtd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirtd_pkg
// Shared constants, types and register codes of the radix digit core.
// ----------------------------------------------------------------------------
package sirtd_pkg;

  localparam int MAX_BASE   = 16;
  localparam int VALUE_BITS = 32;

  localparam int IN_W       = 32;
  localparam int CHAR_W     = 8;
  localparam int NSYM       = 16;
  localparam int SYM_IDX_W  = 4;
  localparam int BLEN_W     = 5;

  localparam int RADIX_W    = $clog2(MAX_BASE + 1);
  localparam int DIGIT_W    = $clog2(MAX_BASE);

  localparam int MAX_DIGITS = VALUE_BITS;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam int CHUNK_W    = 8;
  localparam int CHUNKS     = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int DIV_W      = CHUNKS * CHUNK_W;
  localparam int CHK_W      = $clog2(CHUNKS + 1);

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int PDATA_W    = 64;
  localparam int PADDR_W    = 5;
  localparam int RIDX_W     = 2;

  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SYM_NUL   = 8'h00;

  localparam logic [RIDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [RIDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [RIDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef logic [NSYM-1:0][CHAR_W-1:0] sym_tab_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    sym_tab_t           syms;
  } cfg_t;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

endpackage

[sv/sirtd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirtd_in_if / sirtd_out_if
// Valid/ready channels for input values and output characters.
// ----------------------------------------------------------------------------
interface sirtd_in_if;
  import sirtd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirtd_out_if;
  import sirtd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

[sv/sirtd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirtd_front
// Takes input values, checks the symbol table and queues sign and magnitude.
// ----------------------------------------------------------------------------
module sirtd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sirtd_pkg::cfg_t cfg_i,
  sirtd_in_if.sink        in_ch_i,
  output logic            push_o,
  output sirtd_pkg::job_t push_job_o,
  input  logic            push_ready_i
);
  import sirtd_pkg::*;

  logic                  hold_q, hold_d;
  logic [IN_W-1:0]       val_q;
  logic                  base_ok_q, base_ok_d;
  logic [VALUE_BITS-1:0] raw;
  logic                  consume;

  // Base check: radix of at least two, no sign or NUL symbol, no repeats
  always_comb begin
    base_ok_d = (cfg_i.radix >= RADIX_W'(2));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (RADIX_W'(i) < cfg_i.radix) begin
        if (cfg_i.syms[i] == SYM_NUL || cfg_i.syms[i] == SYM_PLUS ||
            cfg_i.syms[i] == SYM_MINUS) begin
          base_ok_d = 1'b0;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (RADIX_W'(j) < cfg_i.radix && cfg_i.syms[j] == cfg_i.syms[i]) begin
            base_ok_d = 1'b0;
          end
        end
      end
    end
  end

  assign raw              = val_q[VALUE_BITS-1:0];
  assign push_job_o.neg   = raw[VALUE_BITS-1];
  assign push_job_o.mag   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  // Drop the value outright when the base is unusable
  assign consume       = hold_q && (!base_ok_q || push_ready_i);
  assign push_o        = hold_q && base_ok_q && push_ready_i;
  assign in_ch_i.ready = !hold_q || consume;

  always_comb begin
    hold_d = hold_q;
    if (in_ch_i.valid && in_ch_i.ready) begin
      hold_d = 1'b1;
    end else if (consume) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= 1'b0;
      base_ok_q <= 1'b0;
    end else begin
      hold_q    <= hold_d;
      base_ok_q <= base_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_ch_i.ready) begin
      val_q <= in_ch_i.value;
    end
  end

endmodule

[sv/sirtd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirtd_queue
// Short register queue between the front and the digit engine.
// ----------------------------------------------------------------------------
module sirtd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sirtd_pkg::job_t push_job_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output sirtd_pkg::job_t pop_job_o,
  input  logic            pop_i
);
  import sirtd_pkg::*;

  job_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

endmodule

[sv/sirtd_back.sv]
`timescale 1ns / 1ps
`include "signed_integer_to_radix_digits_core_defines.svh"
// ----------------------------------------------------------------------------
// sirtd_back
// Digit engine: long division by the radix, digit stack, character output.
// ----------------------------------------------------------------------------
module sirtd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sirtd_pkg::cfg_t cfg_i,
  input  logic            job_valid_i,
  input  sirtd_pkg::job_t job_i,
  output logic            job_pop_o,
  sirtd_out_if.source     out_ch_o
);
  import sirtd_pkg::*;

  back_state_e        state_q, state_d;
  logic [DIV_W-1:0]   sr_q, sr_n;
  logic [RADIX_W-1:0] rem_q, rem_n;
  logic [CHK_W-1:0]   chunk_q;
  logic [CNT_W-1:0]   ndig_q;
  logic               sign_pend_q;
  logic [DIGIT_W-1:0] stack_q [MAX_DIGITS];
  logic [CNT_W-1:0]   top;
  logic [DIGIT_W-1:0] top_digit;
  logic               chunk_end;
  logic               emit_fire;
  logic               emit_last;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_last_q;

  // One chunk of restoring division per cycle, remainder stays below radix
  always_comb begin
    logic [RADIX_W:0] tmp;
    logic             qb;
    sr_n  = sr_q;
    rem_n = rem_q;
    for (int k = 0; k < CHUNK_W; k++) begin
      tmp   = {rem_n, sr_n[DIV_W-1]};
      qb    = (tmp >= {1'b0, cfg_i.radix});
      if (qb) begin
        tmp = tmp - {1'b0, cfg_i.radix};
      end
      rem_n = tmp[RADIX_W-1:0];
      sr_n  = {sr_n[DIV_W-2:0], qb};
    end
  end

  assign chunk_end = (chunk_q == CHK_W'(CHUNKS - 1));
  assign top       = ndig_q - CNT_W'(1);
  assign top_digit = stack_q[top[IDX_W-1:0]];
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ch_o.ready);
  assign emit_last = !sign_pend_q && (ndig_q == CNT_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (chunk_end && sr_n == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      ndig_q      <= '0;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        chunk_q     <= '0;
        ndig_q      <= '0;
        sign_pend_q <= job_i.neg;
      end else if (state_q == ST_DIV) begin
        if (chunk_end) begin
          chunk_q <= '0;
          ndig_q  <= ndig_q + CNT_W'(1);
        end else begin
          chunk_q <= chunk_q + CHK_W'(1);
        end
      end else if (emit_fire) begin
        if (sign_pend_q) begin
          sign_pend_q <= 1'b0;
        end else begin
          ndig_q <= top;
        end
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      sr_q  <= DIV_W'(job_i.mag);
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      sr_q  <= sr_n;
      // Clear the remainder once a digit is complete
      rem_q <= chunk_end ? '0 : rem_n;
      if (chunk_end) begin
        stack_q[ndig_q[IDX_W-1:0]] <= rem_n[DIGIT_W-1:0];
      end
    end
    if (emit_fire) begin
      out_char_q <= sign_pend_q ? SYM_MINUS : cfg_i.syms[SYM_IDX_W'(top_digit)];
      out_last_q <= emit_last;
    end
  end

  assign out_ch_o.valid    = out_valid_q;
  assign out_ch_o.out_char = out_char_q;
  assign out_ch_o.last     = out_last_q;

  `SIRTD_ASSERT_IMP(a_emit_has_digit, state_q == ST_EMIT, ndig_q != '0, "emit with empty stack")
  `SIRTD_ASSERT_NXT(a_last_ends_item, emit_fire && emit_last, state_q == ST_IDLE,
                    "last character did not end the item")
  `SIRTD_ASSERT_NXT(a_pop_starts_div, job_pop_o, state_q == ST_DIV && ndig_q == '0,
                    "popped job did not start division")

endmodule

[sv/signed_integer_to_radix_digits_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_core
// Writes signed values out as text in a radix set by a table of symbols.
// ----------------------------------------------------------------------------
// Input channel in_ch_i carries one signed value per transaction; output
// channel out_ch_o carries one character per transaction, most significant
// digit first, with a leading '-' for negative values and last set on the
// final character. An invalid symbol table produces no characters at all.
// The APB port holds base_length (0x00), symbols_low (0x08) and
// symbols_high (0x10); program it only while no value is in flight.
// A value with d digits in radix n is divided by n once per digit, one
// 8-bit chunk of the magnitude per cycle in the single divider; then its
// characters go out, d digits plus the sign. Binary values need up to 32
// digits, decimal values up to 10.
// The front stage and a two-entry queue keep accepting values while the
// digit engine works, so input stalls only once the queue is full.
// A receiver stall holds the output register and pauses character output;
// the next queued value is divided only after the last one is registered.
// Reset clears the registers to zero (radix zero: invalid) and empties
// all stages.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sirtd_pkg::PADDR_W-1:0]   paddr,
  input  logic [sirtd_pkg::PDATA_W-1:0]   pwdata,
  output logic [sirtd_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  sirtd_in_if.sink                        in_ch_i,
  sirtd_out_if.source                     out_ch_o
);
  import sirtd_pkg::*;

  logic [BLEN_W-1:0]  base_len_q;
  logic [PDATA_W-1:0] sym_lo_q;
  logic [PDATA_W-1:0] sym_hi_q;
  logic [RIDX_W-1:0]  reg_idx;
  logic               wr_en;
  cfg_t               cfg;
  logic               push;
  job_t               push_job;
  logic               push_ready;
  logic               pop_valid;
  job_t               pop_job;
  logic               pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q <= '0;
      sym_lo_q   <= '0;
      sym_hi_q   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_LENGTH:  base_len_q <= pwdata[BLEN_W-1:0];
        REG_SYMBOLS_LOW:  sym_lo_q   <= pwdata;
        REG_SYMBOLS_HIGH: sym_hi_q   <= pwdata;
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_LENGTH:  prdata = PDATA_W'(base_len_q);
      REG_SYMBOLS_LOW:  prdata = sym_lo_q;
      REG_SYMBOLS_HIGH: prdata = sym_hi_q;
      default:          prdata = '0;
    endcase
  end

  // Clamp the radix to the widest supported base
  assign cfg.radix = (base_len_q > BLEN_W'(MAX_BASE)) ? RADIX_W'(MAX_BASE)
                                                       : RADIX_W'(base_len_q);
  assign cfg.syms  = {sym_hi_q, sym_lo_q};

  sirtd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_ch_i      (in_ch_i),
    .push_o       (push),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  sirtd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_i        (pop)
  );

  sirtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_ch_o    (out_ch_o)
  );

endmodule
